[hw/rtl/br2er_pkg.sv]
`timescale 1ns / 1ps
package br2er_pkg;

  localparam int ANGLE_BITS   = 16;
  localparam int RATE_BITS    = 32;
  localparam int THR_BITS     = 31;
  localparam int CORDIC_STEPS = 30;
  localparam int XW           = 33;   // CORDIC x/y, Q2.30 with headroom
  localparam int ZW           = 34;   // CORDIC residual angle
  localparam int QW           = 63;   // quotient / dividend magnitude bits
  localparam int DW           = 32;   // divisor magnitude bits

  localparam logic [THR_BITS-1:0] THR_RESET  = THR_BITS'(1074);
  localparam logic signed [XW-1:0] CORDIC_X0 = XW'(652032874);
  localparam logic signed [63:0]  RND_HALF   = 64'sd536870912;  // 2^29

  localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  typedef logic signed [RATE_BITS-1:0] rate_t;

  // clamp a wide signed value to the rate range
  function automatic rate_t sat_rate(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< (RATE_BITS - 1)) - 64'sd1;
    lo = -(64'sd1 <<< (RATE_BITS - 1));
    if (v > hi) return rate_t'(hi);
    if (v < lo) return rate_t'(lo);
    return rate_t'(v);
  endfunction

endpackage

[hw/rtl/body_rates_to_euler_rates_top.sv]
`timescale 1ns / 1ps
// Body rates (p, q, r) to 3-2-1 Euler angle rates.
// Input stream s_axis: one beat per sample with roll/pitch binary angles and
// body rates in Q16.16. Output stream m_axis: one beat per sample with the
// roll, pitch and yaw Euler rates (saturated Q16.16); tuser is the gimbal-lock
// flag, in which case all three rates are zero.
// Threshold on |cos(pitch)| (Q2.30) is written through cfg_wr_en_i/data_i; the user
// must write it only while the pipeline is empty; the block does not enforce this.
// Throughput: one beat per cycle while the skid entry is empty. The pipeline has
// 102 register stages: 31 CORDIC, 4 multiply/add, 63 one-bit divider, 3 result,
// output register.
// All stages advance together; a two-entry output buffer (output register
// plus skid) keeps tready on the input high while one finished result waits.
// When the receiver stalls with both entries full the whole pipe holds, and
// no beat is lost or repeated.
// Reset clears all valid bits and loads the threshold with its default 1074.
module body_rates_to_euler_rates_top
  import br2er_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_wr_en_i,
  input  logic [THR_BITS-1:0] cfg_wr_data_i,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // roll_angle, pitch_angle, roll_rate_body, pitch_rate_body, yaw_rate_body
  input  logic [127:0]        s_axis_tdata_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // roll_angle_rate, pitch_angle_rate, yaw_angle_rate
  output logic [95:0]         m_axis_tdata_o,
  // gimbal_lock
  output logic                m_axis_tuser_o
);

  logic [THR_BITS-1:0] thr_q;
  logic en;
  logic skid_v_q, out_v_q;

  // threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (cfg_wr_en_i) begin
      thr_q <= cfg_wr_data_i;
    end
  end

  assign en = !skid_v_q;
  assign s_axis_tready_o = en;

  // input unpack and quadrant fold
  logic [ANGLE_BITS-1:0] ang_in [2];
  logic signed [ZW-1:0]  z_init [2];
  logic                  neg_init [2];
  rate_t p_in, q_in, r_in;

  assign ang_in[0] = s_axis_tdata_i[15:0];
  assign ang_in[1] = s_axis_tdata_i[31:16];
  assign p_in      = s_axis_tdata_i[63:32];
  assign q_in      = s_axis_tdata_i[95:64];
  assign r_in      = s_axis_tdata_i[127:96];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      logic [31:0] ph;
      logic [31:0] tst;
      ph  = {ang_in[l], {(32 - ANGLE_BITS){1'b0}}};
      tst = ph + 32'h40000000;
      neg_init[l] = tst[31];
      if (tst[31]) ph = ph + 32'h80000000;
      z_init[l] = ZW'($signed(ph));
    end
  end

  // CORDIC pipeline, lane 0 = roll, lane 1 = pitch
  logic                 cv_q [0:CORDIC_STEPS];
  logic signed [XW-1:0] cx_q [0:CORDIC_STEPS][2];
  logic signed [XW-1:0] cy_q [0:CORDIC_STEPS][2];
  logic signed [ZW-1:0] cz_q [0:CORDIC_STEPS][2];
  logic                 cn_q [0:CORDIC_STEPS][2];
  rate_t                cp_q [0:CORDIC_STEPS];
  rate_t                cq_q [0:CORDIC_STEPS];
  rate_t                cr_q [0:CORDIC_STEPS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q[0] <= 1'b0;
    end else if (en) begin
      cv_q[0] <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        cx_q[0][l] <= CORDIC_X0;
        cy_q[0][l] <= '0;
        cz_q[0][l] <= z_init[l];
        cn_q[0][l] <= neg_init[l];
      end
      cp_q[0] <= p_in;
      cq_q[0] <= q_in;
      cr_q[0] <= r_in;
    end
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cv_q[k+1] <= 1'b0;
      end else if (en) begin
        cv_q[k+1] <= cv_q[k];
      end
    end

    // one micro-rotation per stage
    always_ff @(posedge clk_i) begin
      if (en) begin
        for (int l = 0; l < 2; l++) begin
          if (!cz_q[k][l][ZW-1]) begin
            cx_q[k+1][l] <= cx_q[k][l] - (cy_q[k][l] >>> k);
            cy_q[k+1][l] <= cy_q[k][l] + (cx_q[k][l] >>> k);
            cz_q[k+1][l] <= cz_q[k][l] - $signed({2'b00, ATAN_TAB[k]});
          end else begin
            cx_q[k+1][l] <= cx_q[k][l] + (cy_q[k][l] >>> k);
            cy_q[k+1][l] <= cy_q[k][l] - (cx_q[k][l] >>> k);
            cz_q[k+1][l] <= cz_q[k][l] + $signed({2'b00, ATAN_TAB[k]});
          end
          cn_q[k+1][l] <= cn_q[k][l];
        end
        cp_q[k+1] <= cp_q[k];
        cq_q[k+1] <= cq_q[k];
        cr_q[k+1] <= cr_q[k];
      end
    end
  end

  // M0: undo quadrant fold
  logic                 m0v_q;
  logic signed [XW-1:0] sphi_q, cphi_q, stht_m0_q, ctht_q;
  rate_t                p_m0_q, q_m0_q, r_m0_q;

  // M1: products, |cos(pitch)|, lock test
  logic                 m1v_q;
  logic signed [63:0]   sq_q, cr_prod_q, cq_prod_q, sr_q;
  logic [DW-1:0]        cabs_m1_q;
  logic                 csgn_m1_q, lock_m1_q;
  logic signed [XW-1:0] stht_m1_q;
  rate_t                p_m1_q;

  // M2: sums
  logic                 m2v_q;
  logic signed [63:0]   t_q, pdsum_q;
  logic [DW-1:0]        cabs_m2_q;
  logic                 csgn_m2_q, lock_m2_q;
  logic signed [XW-1:0] stht_m2_q;
  rate_t                p_m2_q;

  logic signed [XW:0]   ctht_ext;
  logic signed [XW:0]   ctht_abs;
  assign ctht_ext = {ctht_q[XW-1], ctht_q};
  assign ctht_abs = ctht_ext[XW] ? -ctht_ext : ctht_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m0v_q <= 1'b0;
      m1v_q <= 1'b0;
      m2v_q <= 1'b0;
    end else if (en) begin
      m0v_q <= cv_q[CORDIC_STEPS];
      m1v_q <= m0v_q;
      m2v_q <= m1v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sphi_q    <= cn_q[CORDIC_STEPS][0] ? -cy_q[CORDIC_STEPS][0] : cy_q[CORDIC_STEPS][0];
      cphi_q    <= cn_q[CORDIC_STEPS][0] ? -cx_q[CORDIC_STEPS][0] : cx_q[CORDIC_STEPS][0];
      stht_m0_q <= cn_q[CORDIC_STEPS][1] ? -cy_q[CORDIC_STEPS][1] : cy_q[CORDIC_STEPS][1];
      ctht_q    <= cn_q[CORDIC_STEPS][1] ? -cx_q[CORDIC_STEPS][1] : cx_q[CORDIC_STEPS][1];
      p_m0_q    <= cp_q[CORDIC_STEPS];
      q_m0_q    <= cq_q[CORDIC_STEPS];
      r_m0_q    <= cr_q[CORDIC_STEPS];

      sq_q      <= sphi_q * q_m0_q;
      cr_prod_q <= cphi_q * r_m0_q;
      cq_prod_q <= cphi_q * q_m0_q;
      sr_q      <= sphi_q * r_m0_q;
      cabs_m1_q <= ctht_abs[DW-1:0];
      csgn_m1_q <= ctht_q[XW-1];
      lock_m1_q <= ($unsigned(ctht_abs) <= (XW+1)'(thr_q));
      stht_m1_q <= stht_m0_q;
      p_m1_q    <= p_m0_q;

      t_q       <= sq_q + cr_prod_q;
      pdsum_q   <= cq_prod_q - sr_q + RND_HALF;
      cabs_m2_q <= cabs_m1_q;
      csgn_m2_q <= csgn_m1_q;
      lock_m2_q <= lock_m1_q;
      stht_m2_q <= stht_m1_q;
      p_m2_q    <= p_m1_q;
    end
  end

  // M3 feeds the divider: magnitudes and quotient sign
  logic                 dv_q   [0:QW];
  logic [DW-1:0]        rem_q  [0:QW];
  logic [QW-1:0]        num_q  [0:QW];
  logic [DW-1:0]        dvs_q  [0:QW];
  logic                 qs_q   [0:QW];
  logic                 lk_q   [0:QW];
  logic signed [XW-1:0] ds_q   [0:QW];
  rate_t                dp_q   [0:QW];
  rate_t                dpd_q  [0:QW];

  logic signed [63:0] t_abs;
  assign t_abs = t_q[63] ? -t_q : t_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else if (en) begin
      dv_q[0] <= m2v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rem_q[0] <= '0;
      num_q[0] <= t_abs[QW-1:0];
      dvs_q[0] <= cabs_m2_q;
      qs_q[0]  <= t_q[63] ^ csgn_m2_q;
      lk_q[0]  <= lock_m2_q;
      ds_q[0]  <= stht_m2_q;
      dp_q[0]  <= p_m2_q;
      dpd_q[0] <= sat_rate(pdsum_q >>> 30);
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [DW:0] trial;
    logic        fit;
    assign trial = {rem_q[k], num_q[k][QW-1]};
    assign fit   = trial >= {1'b0, dvs_q[k]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k+1] <= 1'b0;
      end else if (en) begin
        dv_q[k+1] <= dv_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        rem_q[k+1] <= fit ? DW'(trial - {1'b0, dvs_q[k]}) : trial[DW-1:0];
        num_q[k+1] <= {num_q[k][QW-2:0], fit};
        dvs_q[k+1] <= dvs_q[k];
        qs_q[k+1]  <= qs_q[k];
        lk_q[k+1]  <= lk_q[k];
        ds_q[k+1]  <= ds_q[k];
        dp_q[k+1]  <= dp_q[k];
        dpd_q[k+1] <= dpd_q[k];
      end
    end
  end

  // R1: signed quotient
  logic                 r1v_q, r2v_q, r3v_q;
  logic signed [63:0]   e_q;
  logic                 lk_r1_q, lk_r2_q, lk_r3_q;
  logic signed [XW-1:0] s_r1_q;
  rate_t                p_r1_q, p_r2_q, p_r3_q;
  rate_t                pd_r1_q, pd_r2_q, pd_r3_q;
  rate_t                yaw_r2_q, yaw_r3_q;
  logic signed [63:0]   ph_q, pl_q, term_q;

  logic signed [33:0] e_hi;
  logic [29:0]        e_lo;
  assign e_hi = e_q[63:30];
  assign e_lo = e_q[29:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r1v_q <= 1'b0;
      r2v_q <= 1'b0;
      r3v_q <= 1'b0;
    end else if (en) begin
      r1v_q <= dv_q[QW];
      r2v_q <= r1v_q;
      r3v_q <= r2v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_q      <= qs_q[QW] ? -$signed({1'b0, num_q[QW]}) : $signed({1'b0, num_q[QW]});
      lk_r1_q  <= lk_q[QW];
      s_r1_q   <= ds_q[QW];
      p_r1_q   <= dp_q[QW];
      pd_r1_q  <= dpd_q[QW];

      // split e * sin(pitch) into high and low partial products
      ph_q     <= e_hi * s_r1_q;
      pl_q     <= $signed({1'b0, e_lo}) * s_r1_q;
      yaw_r2_q <= sat_rate(e_q);
      lk_r2_q  <= lk_r1_q;
      p_r2_q   <= p_r1_q;
      pd_r2_q  <= pd_r1_q;

      term_q   <= ph_q + ((pl_q + RND_HALF) >>> 30);
      yaw_r3_q <= yaw_r2_q;
      lk_r3_q  <= lk_r2_q;
      p_r3_q   <= p_r2_q;
      pd_r3_q  <= pd_r2_q;
    end
  end

  // final result
  logic [95:0] res_data;
  rate_t       roll_res;
  assign roll_res = sat_rate(64'(p_r3_q) + term_q);
  assign res_data = lk_r3_q ? '0 : {yaw_r3_q, pd_r3_q, roll_res};

  // output register plus skid entry
  logic [95:0] out_d_q, skid_d_q;
  logic        out_u_q, skid_u_q;
  logic        push, pop;
  assign push = en && r3v_q;
  assign pop  = out_v_q && m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (pop) skid_v_q <= 1'b0;
    end else if (push) begin
      if (!out_v_q || pop) out_v_q <= 1'b1;
      else                 skid_v_q <= 1'b1;
    end else if (pop) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (pop) begin
        out_d_q <= skid_d_q;
        out_u_q <= skid_u_q;
      end
    end else if (push) begin
      if (!out_v_q || pop) begin
        out_d_q <= res_data;
        out_u_q <= lk_r3_q;
      end else begin
        skid_d_q <= res_data;
        skid_u_q <= lk_r3_q;
      end
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = out_d_q;
  assign m_axis_tuser_o  = out_u_q;

  // checks
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid entry held without output entry");

  a_skid_refills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_v_q && pop) |=> out_v_q)
    else $error("output emptied while skid entry pending");

  a_lock_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tdata_o == '0))
    else $error("gimbal lock beat with nonzero rates");

endmodule
